>>> design/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation engine.
// Used by design/modular_exponentiation.sv; needs clk and rst_n in scope.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mexp_pkg.sv
// Shared constants for the modular exponentiation engine.
// No dependencies; imported by design/modular_exponentiation.sv and bench/modular_exponentiation_tb.sv.
package mexp_pkg;

    // Width of every payload field and configuration register
    localparam int FIELD_WIDTH = 32;
    // Default arithmetic word width
    localparam int WORD_WIDTH_DEFAULT = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS          = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRIVATE_EXPONENT = 2'd2;

    // Register reset values
    localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET          = 32'd21;
    localparam logic [FIELD_WIDTH-1:0] PUBLIC_EXPONENT_RESET  = 32'd5;
    localparam logic [FIELD_WIDTH-1:0] PRIVATE_EXPONENT_RESET = 32'd5;

    // Opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

endpackage

>>> design/modular_exponentiation.sv
// Top level of the modular exponentiation engine: config registers and the full pipeline.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
//
// Computes message_value ^ exponent mod modulus, the exponent picked by opcode (encrypt uses
// the public exponent, decrypt the private one). The engine is a fixed pipeline of one input
// stage, WORD_WIDTH reduction stages (restoring base mod modulus, one bit each) and
// WORD_WIDTH * WORD_WIDTH multiply stages: per exponent bit, the running result and the
// squared base are each advanced by one shift-and-add modular step per stage. A new word can
// be transferred every cycle unless the pipeline is halted: it halts as a whole while a
// finished result is stalled at the output, and then in_stall is raised. A zero modulus
// gives 0, a modulus of one gives 0.
// Write the configuration registers only while no transfer is in flight.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [FIELD_WIDTH-1:0]     cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic [FIELD_WIDTH-1:0]     message_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [FIELD_WIDTH-1:0]     result_value
);

    localparam int W  = WORD_WIDTH;
    localparam int NS = W + W * W;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        logic  mod_zero;
        word_t m;
        word_t e;
        word_t r;
        word_t b;
        word_t acc_r;
        word_t acc_s;
    } pipe_t;

    // (a + b) mod m for a, b < m
    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        word_t gap;
        gap = m - b;
        if (a >= gap)
        begin
            return a - gap;
        end
        return a + b;
    endfunction

    logic [FIELD_WIDTH-1:0] modulus_reg;
    logic [FIELD_WIDTH-1:0] public_exponent_reg;
    logic [FIELD_WIDTH-1:0] private_exponent_reg;

    pipe_t pipe_reg  [0:NS];
    pipe_t pipe_next [0:NS];
    logic  valid_reg [0:NS];
    logic  advance;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg          <= MODULUS_RESET;
            public_exponent_reg  <= PUBLIC_EXPONENT_RESET;
            private_exponent_reg <= PRIVATE_EXPONENT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MODULUS:          modulus_reg          <= cfg_data;
                CFG_PUBLIC_EXPONENT:  public_exponent_reg  <= cfg_data;
                CFG_PRIVATE_EXPONENT: private_exponent_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Advance the whole pipeline unless a finished result is held at the output
    assign advance  = !(valid_reg[NS] && out_stall);
    assign in_stall = !advance;

    // Entry stage: truncate fields, pick the exponent, seed the running result with 1 mod m
    always_comb
    begin
        word_t m_in;
        m_in = W'(modulus_reg);
        pipe_next[0].mod_zero = (m_in == '0);
        pipe_next[0].m        = m_in;
        pipe_next[0].e        = (opcode == OP_DECRYPT) ? W'(private_exponent_reg)
                                                       : W'(public_exponent_reg);
        pipe_next[0].r        = (m_in == word_t'(1)) ? '0 : word_t'(1);
        pipe_next[0].b        = W'(message_value);
        pipe_next[0].acc_r    = '0;
        pipe_next[0].acc_s    = '0;
    end

    // Pipeline stage logic
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        if (s < W)
        begin : g_reduce
            // One restoring step of base mod m; acc_r holds the partial remainder
            always_comb
            begin
                logic [W:0] t;
                word_t      rem;
                t   = {pipe_reg[s].acc_r, pipe_reg[s].b[W-1]};
                rem = (t >= {1'b0, pipe_reg[s].m}) ? W'(t - {1'b0, pipe_reg[s].m}) : W'(t);
                pipe_next[s+1] = pipe_reg[s];
                if (s == W - 1)
                begin
                    pipe_next[s+1].b     = rem;
                    pipe_next[s+1].acc_r = '0;
                end
                else
                begin
                    pipe_next[s+1].b     = pipe_reg[s].b << 1;
                    pipe_next[s+1].acc_r = rem;
                end
            end
        end
        else
        begin : g_mult
            localparam int J   = (s - W) % W;
            localparam int BIT = W - 1 - J;
            // One shift-and-add step of r*b mod m and b*b mod m
            always_comb
            begin
                word_t ar;
                word_t as;
                ar = add_mod(pipe_reg[s].acc_r, pipe_reg[s].acc_r, pipe_reg[s].m);
                as = add_mod(pipe_reg[s].acc_s, pipe_reg[s].acc_s, pipe_reg[s].m);
                if (pipe_reg[s].b[BIT])
                begin
                    ar = add_mod(ar, pipe_reg[s].r, pipe_reg[s].m);
                    as = add_mod(as, pipe_reg[s].b, pipe_reg[s].m);
                end
                pipe_next[s+1] = pipe_reg[s];
                if (J == W - 1)
                begin
                    // Close one exponent bit: take the product if set, square the base
                    if (pipe_reg[s].e[0])
                    begin
                        pipe_next[s+1].r = ar;
                    end
                    pipe_next[s+1].b     = as;
                    pipe_next[s+1].e     = pipe_reg[s].e >> 1;
                    pipe_next[s+1].acc_r = '0;
                    pipe_next[s+1].acc_s = '0;
                end
                else
                begin
                    pipe_next[s+1].acc_r = ar;
                    pipe_next[s+1].acc_s = as;
                end
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Payload registers: hold while halted
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pipe_reg[0] <= pipe_next[0];
            for (int i = 1; i <= NS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // Drive the result from the last stage
    assign out_valid    = valid_reg[NS];
    assign result_value = pipe_reg[NS].mod_zero ? '0 : FIELD_WIDTH'(pipe_reg[NS].r);

    // Checks
    `MEXP_ASSERT_NEXT(a_entry_valid, in_valid && !in_stall, valid_reg[0],
        "accepted word did not enter the pipeline")
    `MEXP_ASSERT_NOW(a_stall_link, valid_reg[NS] && out_stall, in_stall,
        "input taken while the output is held")
    `MEXP_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid,
        "held result dropped")
    `MEXP_ASSERT_NOW(a_result_range, out_valid && pipe_reg[NS].m > word_t'(1),
        W'(result_value) < pipe_reg[NS].m, "result not reduced below modulus")

endmodule

>>> bench/modular_exponentiation_tb.sv
// Self-checking bench for the modular exponentiation engine.
// Depends on mexp_pkg and design/modular_exponentiation.sv; drives transfers, predicts powers.
module modular_exponentiation_tb;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it are dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 1057;
    localparam int LONG_HOLD = 1600;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                   op;
        logic [FIELD_WIDTH-1:0] word;
    } word_item_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [FIELD_WIDTH-1:0]     cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       opcode;
    logic [FIELD_WIDTH-1:0]     message_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [FIELD_WIDTH-1:0]     result_value;

    // Bench copy of the key registers
    logic [FIELD_WIDTH-1:0] key_modulus;
    logic [FIELD_WIDTH-1:0] key_public;
    logic [FIELD_WIDTH-1:0] key_private;

    word_item_t             pending_words[$];
    logic [FIELD_WIDTH-1:0] expected_powers[$];
    int                     fail_count;
    logic                   in_taken;
    int                     in_gap;
    int                     out_gap;
    int                     hold_left;
    logic                   hold_request;
    longint                 cycle_count;

    modular_exponentiation u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .message_value (message_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Square-and-multiply on 64-bit products, base reduced first
    function automatic logic [FIELD_WIDTH-1:0] power_mod(logic op, logic [FIELD_WIDTH-1:0] word);
        longint unsigned m;
        longint unsigned e;
        longint unsigned r;
        longint unsigned b;
        m = key_modulus;
        e = (op == OP_DECRYPT) ? key_private : key_public;
        if (m == 0)
            return '0;
        r = 1 % m;
        b = word % m;
        while (e != 0)
        begin
            if (e[0])
                r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r[FIELD_WIDTH-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Record transfers on both channels and check results
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_powers.push_back(power_mod(opcode, message_value));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("result_value: no result expected, actual %0h", result_value);
                fail_count++;
            end
            else
            begin
                if (result_value !== expected_powers[0])
                begin
                    $error("result_value: expected %0h, actual %0h",
                           expected_powers[0], result_value);
                    fail_count++;
                end
                void'(expected_powers.pop_front());
            end
        end
    end

    // Input driver: hold a stalled word, otherwise advance after a gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                word_item_t w;
                w = pending_words.pop_front();
                in_valid      <= 1'b1;
                opcode        <= w.op;
                message_value <= w.word;
                in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall: random gaps, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(99) < 30)
                out_gap = pick_gap();
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [FIELD_WIDTH-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_MODULUS:          key_modulus = value;
            CFG_PUBLIC_EXPONENT:  key_public  = value;
            CFG_PRIVATE_EXPONENT: key_private = value;
            default: ;
        endcase
    endtask

    task automatic set_keys(logic [FIELD_WIDTH-1:0] m, logic [FIELD_WIDTH-1:0] pub,
                            logic [FIELD_WIDTH-1:0] priv);
        write_reg(CFG_MODULUS, m);
        write_reg(CFG_PUBLIC_EXPONENT, pub);
        write_reg(CFG_PRIVATE_EXPONENT, priv);
    endtask

    // Wait until every queued word has gone through and its result has come back
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_powers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_word(logic op, logic [FIELD_WIDTH-1:0] word);
        pending_words.push_back('{op: op, word: word});
    endtask

    // Edge words for the current modulus, both operations
    task automatic queue_edges();
        logic [FIELD_WIDTH-1:0] edge_words[6];
        edge_words = '{32'd0, 32'd1, key_modulus - 1, key_modulus, 32'hFFFF_FFFF, 32'h8000_0000};
        foreach (edge_words[i])
        begin
            queue_word(OP_ENCRYPT, edge_words[i]);
            queue_word(OP_DECRYPT, edge_words[i]);
        end
    endtask

    task automatic queue_random(int count);
        logic [FIELD_WIDTH-1:0] w;
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                w = $urandom;
            else if (roll < 80)
                w = $urandom_range(15);
            else
                w = key_modulus + $urandom_range(4) - 2;
            queue_word(1'($urandom_range(1)), w);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_MODULUS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_ENCRYPT;
        message_value = '0;
        out_stall    = 1'b0;
        in_taken     = 1'b0;
        in_gap       = 0;
        out_gap      = 0;
        hold_left    = 0;
        hold_request = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        key_modulus  = MODULUS_RESET;
        key_public   = PUBLIC_EXPONENT_RESET;
        key_private  = PRIVATE_EXPONENT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset keys, then a write to the unused index must change nothing
        queue_edges();
        drain();
        write_reg(CFG_UNUSED, 32'd7);
        queue_word(OP_ENCRYPT, 32'd2);
        queue_word(OP_DECRYPT, 32'd20);
        drain();

        // Zero modulus, modulus of one, zero exponents (covers zero to the zero)
        set_keys(32'd0, 32'd3, 32'd7);
        queue_edges();
        drain();
        set_keys(32'd1, 32'hFFFF_FFFF, 32'd2);
        queue_edges();
        drain();
        set_keys(32'd97, 32'd0, 32'd0);
        queue_edges();
        drain();

        // Widest modulus and exponents, with the long output hold to fill the pipe
        set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_edges();
        hold_request = 1'b1;
        queue_random(500);
        drain();

        // Textbook key pair, then random keys
        set_keys(32'd3233, 32'd17, 32'd2753);
        queue_random(100);
        drain();
        set_keys(32'd2, 32'hFFFF_FFFE, 32'd1);
        queue_random(40);
        drain();
        repeat (3)
        begin
            set_keys($urandom, $urandom, $urandom);
            queue_random(100);
            drain();
        end

        repeat (PIPE_LATENCY + 50) @(posedge clk);
        if (fail_count == 0 && expected_powers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/mexp_pkg.sv
design/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
